>>> design/utf8vr_pkg.sv
// Package for the UTF-8 validity ratio unit: widths, byte classes,
// control and status structs shared by the parser, divider and top level.
// Depends on nothing.
package utf8vr_pkg;

	localparam int COUNT_WIDTH         = 32;
	localparam int RATIO_FRACTION_BITS = 16;
	localparam int RATIO_WIDTH         = RATIO_FRACTION_BITS + 1;
	localparam int STEP_WIDTH          = $clog2(RATIO_FRACTION_BITS + 1);
	localparam int OUT_DATA_WIDTH      = ((2 * COUNT_WIDTH + RATIO_WIDTH + 7) / 8) * 8;
	localparam int OUT_PAD_WIDTH       = OUT_DATA_WIDTH - 2 * COUNT_WIDTH - RATIO_WIDTH;

	localparam logic [7:0] MASK_TOP1  = 8'h80;
	localparam logic [7:0] MASK_TOP2  = 8'hC0;
	localparam logic [7:0] MASK_TOP3  = 8'hE0;
	localparam logic [7:0] MASK_TOP4  = 8'hF0;
	localparam logic [7:0] MASK_TOP5  = 8'hF8;
	localparam logic [7:0] CONT_BITS  = 8'h80;
	localparam logic [7:0] LEAD2_BITS = 8'hC0;
	localparam logic [7:0] LEAD3_BITS = 8'hE0;
	localparam logic [7:0] LEAD4_BITS = 8'hF0;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] SECOND_A0  = 8'hA0;
	localparam logic [7:0] SECOND_90  = 8'h90;
	localparam logic [7:0] SECOND_8F  = 8'h8F;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [RATIO_WIDTH-1:0] ratio_t;

	typedef struct packed {
		logic       take;
		logic [7:0] data;
		logic       flush;
		logic       clear;
	} parse_ctrl_t;

	typedef struct packed {
		logic   flush_busy;
		count_t valid_count;
		count_t total_count;
	} parse_status_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & MASK_TOP2) == CONT_BITS;
	endfunction

endpackage

>>> design/utf8_validity_ratio_unit.sv
// Top level of the UTF-8 validity ratio unit: stream ports, sequencer and
// result register. Depends on utf8vr_pkg, utf8vr_parser and utf8vr_divider.
//
// Bytes are taken at one request per cycle while no buffer end is in
// progress. A request with tlast set starts the end of buffer. The parser
// drops a pending lead and replays the bytes held after it, one step per
// cycle and at most six steps for the longest chain of truncated leads.
// Then the sequencer starts the restoring divider, which forms the quotient
// one fraction bit at a time and then hands it over. So tready stays low
// from the tlast request until the divider is done; for an empty buffer the
// divider skips the quotient bits. The result register holds one result, so
// the next buffer streams in while it waits, and a following buffer end
// waits for it to be taken before the divider starts.
module utf8_validity_ratio_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [7:0]                             s_tdata,  // data_byte
	input  logic                                   s_tuser,  // has_byte
	input  logic                                   s_tlast,  // last
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// valid count, sequence count, validity_ratio, zero fill
	output logic [utf8vr_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);
	import utf8vr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FLUSH = 3'b010,
		ST_DIV   = 3'b100
	} state_t;

	state_t        state_q;
	parse_ctrl_t   pctrl;
	parse_status_t pstat;
	logic          accept;
	logic          div_start;
	logic          div_done;
	ratio_t        div_quo;
	logic          out_valid_q;
	count_t        out_valid_cnt_q;
	count_t        out_total_cnt_q;
	ratio_t        out_ratio_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign div_start = (state_q == ST_FLUSH) && !pstat.flush_busy && !out_valid_q;

	always_comb begin
		pctrl.take  = accept && s_tuser;
		pctrl.data  = s_tdata;
		pctrl.flush = (state_q == ST_FLUSH);
		pctrl.clear = div_start;
	end

	utf8vr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctrl),
		.status (pstat)
	);

	utf8vr_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pstat.valid_count),
		.divisor  (pstat.total_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tlast) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			out_valid_cnt_q <= pstat.valid_count;
			out_total_cnt_q <= pstat.total_count;
		end
		if (state_q == ST_DIV && div_done) begin
			out_ratio_q <= div_quo;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_WIDTH{1'b0}}, out_ratio_q, out_total_cnt_q, out_valid_cnt_q};

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_ratio_q <= (ratio_t'(1) << RATIO_FRACTION_BITS))
		else $error("ratio above one");

	a_empty_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_total_cnt_q == '0) |->
		out_ratio_q == (ratio_t'(1) << RATIO_FRACTION_BITS))
		else $error("empty buffer does not give a ratio of one");

	a_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_total_cnt_q == out_valid_cnt_q) |->
		out_ratio_q == (ratio_t'(1) << RATIO_FRACTION_BITS))
		else $error("all sequences valid but ratio below one");

endmodule

>>> design/utf8vr_parser.sv
// Byte parser for the UTF-8 validity ratio unit: sequence state, replay of
// held bytes at the end of a buffer, and the saturating counters.
// Depends on utf8vr_pkg.
module utf8vr_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  utf8vr_pkg::parse_ctrl_t   ctrl,
	output utf8vr_pkg::parse_status_t status
);
	import utf8vr_pkg::*;

	logic [7:0] lead_q;
	logic [7:0] follow_q [2];
	logic [1:0] needed_q;
	logic [1:0] held_q;
	logic [7:0] replay_q [2];
	logic [1:0] replay_cnt_q;
	count_t     valid_q;
	count_t     total_q;

	logic [7:0] lead_n;
	logic [7:0] follow_n [2];
	logic [1:0] needed_n;
	logic [1:0] held_n;
	logic [7:0] replay_n [2];
	logic [1:0] replay_cnt_n;
	logic       replay_active;
	logic       do_take;
	logic       do_drop;
	logic [7:0] src;
	logic [7:0] second;
	logic       judge_ok;
	logic       cnt_en;
	logic       cnt_ok;

	assign replay_active = ctrl.flush && (replay_cnt_q != 2'd0);
	assign do_take       = ctrl.take || replay_active;
	assign do_drop       = ctrl.flush && (replay_cnt_q == 2'd0) && (needed_q != 2'd0);
	assign src           = replay_active ? replay_q[0] : ctrl.data;

	always_comb begin
		second   = (held_q >= 2'd1) ? follow_q[0] : src;
		judge_ok = is_cont(src);
		if (held_q >= 2'd1) begin
			judge_ok = judge_ok && is_cont(follow_q[0]);
		end
		if (held_q >= 2'd2) begin
			judge_ok = judge_ok && is_cont(follow_q[1]);
		end
		if (lead_q == LEAD_E0 && second < SECOND_A0) judge_ok = 1'b0;
		if (lead_q == LEAD_ED && second >= SECOND_A0) judge_ok = 1'b0;
		if (lead_q == LEAD_F0 && second < SECOND_90) judge_ok = 1'b0;
		if (lead_q == LEAD_F4 && second > SECOND_8F) judge_ok = 1'b0;
	end

	always_comb begin
		lead_n       = lead_q;
		follow_n     = follow_q;
		needed_n     = needed_q;
		held_n       = held_q;
		replay_n     = replay_q;
		replay_cnt_n = replay_cnt_q;
		cnt_en       = 1'b0;
		cnt_ok       = 1'b0;
		if (do_drop) begin
			cnt_en       = 1'b1;
			replay_n[0]  = follow_q[0];
			replay_n[1]  = follow_q[1];
			replay_cnt_n = (held_q > 2'd2) ? 2'd2 : held_q;
			needed_n     = 2'd0;
			held_n       = 2'd0;
			lead_n       = 8'h00;
		end else if (do_take) begin
			if (replay_active) begin
				replay_n[0]  = replay_q[1];
				replay_cnt_n = replay_cnt_q - 2'd1;
			end
			unique case (needed_q)
				2'd0: begin
					held_n = 2'd0;
					if ((src & MASK_TOP1) == 8'h00) begin
						cnt_en = 1'b1;
						cnt_ok = 1'b1;
					end else if ((src & MASK_TOP3) == LEAD2_BITS && src >= LEAD2_MIN) begin
						lead_n   = src;
						needed_n = 2'd1;
					end else if ((src & MASK_TOP4) == LEAD3_BITS) begin
						lead_n   = src;
						needed_n = 2'd2;
					end else if ((src & MASK_TOP5) == LEAD4_BITS && src <= LEAD4_MAX) begin
						lead_n   = src;
						needed_n = 2'd3;
					end else begin
						cnt_en = 1'b1;
					end
				end
				2'd1: begin
					cnt_en   = 1'b1;
					cnt_ok   = judge_ok;
					needed_n = 2'd0;
					held_n   = 2'd0;
					lead_n   = 8'h00;
				end
				default: begin
					follow_n[held_q[0]] = src;
					held_n              = held_q + 2'd1;
					needed_n            = needed_q - 2'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q       <= 8'h00;
			follow_q[0]  <= 8'h00;
			follow_q[1]  <= 8'h00;
			needed_q     <= 2'd0;
			held_q       <= 2'd0;
			replay_q[0]  <= 8'h00;
			replay_q[1]  <= 8'h00;
			replay_cnt_q <= 2'd0;
			valid_q      <= '0;
			total_q      <= '0;
		end else if (ctrl.clear) begin
			lead_q       <= 8'h00;
			follow_q[0]  <= 8'h00;
			follow_q[1]  <= 8'h00;
			needed_q     <= 2'd0;
			held_q       <= 2'd0;
			replay_cnt_q <= 2'd0;
			valid_q      <= '0;
			total_q      <= '0;
		end else begin
			lead_q       <= lead_n;
			follow_q     <= follow_n;
			needed_q     <= needed_n;
			held_q       <= held_n;
			replay_q     <= replay_n;
			replay_cnt_q <= replay_cnt_n;
			if (cnt_en && total_q != '1) begin
				total_q <= total_q + count_t'(1);
			end
			if (cnt_en && cnt_ok && valid_q != '1) begin
				valid_q <= valid_q + count_t'(1);
			end
		end
	end

	assign status.flush_busy  = (needed_q != 2'd0) || (replay_cnt_q != 2'd0);
	assign status.valid_count = valid_q;
	assign status.total_count = total_q;

	a_valid_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= total_q)
		else $error("valid count exceeds total count");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3 && replay_cnt_q != 2'd3)
		else $error("held or replay count out of range");

endmodule

>>> design/utf8vr_divider.sv
// Restoring divider that forms valid over total as an unsigned Q1.16 fraction,
// one quotient bit per cycle. Depends on utf8vr_pkg.
module utf8vr_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  utf8vr_pkg::count_t dividend,
	input  utf8vr_pkg::count_t divisor,
	output logic               done,
	output utf8vr_pkg::ratio_t quotient
);
	import utf8vr_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_WIDTH-1:0] step_q;
	count_t                rem_q;
	count_t                div_q;
	ratio_t                quo_q;
	logic [COUNT_WIDTH:0]  rem_shift;
	logic                  fits;

	assign rem_shift = {rem_q, 1'b0};
	assign fits      = rem_shift >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= start ? (divisor == '0) : (busy_q && step_q == STEP_WIDTH'(1));
			if (start) begin
				busy_q <= (divisor != '0);
				step_q <= STEP_WIDTH'(RATIO_FRACTION_BITS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_WIDTH'(1);
				if (step_q == STEP_WIDTH'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			if (divisor == '0) begin
				quo_q <= ratio_t'(1) << RATIO_FRACTION_BITS;
				rem_q <= '0;
			end else if (dividend >= divisor) begin
				quo_q <= ratio_t'(1);
				rem_q <= dividend - divisor;
			end else begin
				quo_q <= '0;
				rem_q <= dividend;
			end
		end else if (busy_q) begin
			quo_q <= {quo_q[RATIO_WIDTH-2:0], fits};
			rem_q <= fits ? COUNT_WIDTH'(rem_shift - {1'b0, div_q})
			              : rem_shift[COUNT_WIDTH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> tb/sv/tb_utf8_validity_ratio_unit.sv
// Testbench for utf8_validity_ratio_unit: streams byte buffers through the
// unit and compares each end-of-buffer summary with its own prediction.
// Depends on utf8vr_pkg and the RTL of utf8_validity_ratio_unit only.
module tb_utf8_validity_ratio_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8vr_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int STALL_LIMIT     = 4000;
	localparam int ITEM_TARGET     = 1100;

	typedef struct packed {
		count_t valid;
		count_t total;
		ratio_t ratio;
	} buffer_counts_t;

	logic                      clk;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata  = 8'h00;
	logic                      s_tuser  = 1'b0;
	logic                      s_tlast  = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;

	logic        holding      = 1'b0;
	bit          no_idle_send = 1'b0;
	bit          no_idle_recv = 1'b0;
	int unsigned items_sent   = 0;
	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned stall_cycles = 0;
	event        hold_off_go;

	buffer_counts_t expected_counts_q[$];

	// Parser state of the prediction.
	logic [7:0] seq_lead;
	logic [7:0] seq_follow [2];
	logic [1:0] seq_need;
	logic [1:0] seq_held;
	count_t     valid_tally;
	count_t     total_tally;

	utf8_validity_ratio_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_parser();
		seq_lead      = 8'h00;
		seq_follow[0] = 8'h00;
		seq_follow[1] = 8'h00;
		seq_need      = 2'd0;
		seq_held      = 2'd0;
		valid_tally   = '0;
		total_tally   = '0;
	endfunction

	function automatic void count_sequence(input logic ok);
		if (total_tally != '1)
			total_tally++;
		if (ok && valid_tally != '1)
			valid_tally++;
	endfunction

	function automatic void judge_sequence(input logic [7:0] fin);
		logic [7:0] second;
		logic       ok;
		ok = (fin & MASK_TOP2) == CONT_BITS;
		second = fin;
		if (seq_held >= 2'd1) begin
			second = seq_follow[0];
			ok = ok && ((seq_follow[0] & MASK_TOP2) == CONT_BITS);
		end
		if (seq_held >= 2'd2)
			ok = ok && ((seq_follow[1] & MASK_TOP2) == CONT_BITS);
		if (seq_lead == LEAD_E0 && second < SECOND_A0) ok = 1'b0;
		if (seq_lead == LEAD_ED && second >= SECOND_A0) ok = 1'b0;
		if (seq_lead == LEAD_F0 && second < SECOND_90) ok = 1'b0;
		if (seq_lead == LEAD_F4 && second > SECOND_8F) ok = 1'b0;
		count_sequence(ok);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		if (seq_need == 2'd0) begin
			seq_held = 2'd0;
			if ((b & MASK_TOP1) == 8'h00) begin
				count_sequence(1'b1);
			end else if ((b & MASK_TOP3) == LEAD2_BITS && b >= LEAD2_MIN) begin
				seq_lead = b;
				seq_need = 2'd1;
			end else if ((b & MASK_TOP4) == LEAD3_BITS) begin
				seq_lead = b;
				seq_need = 2'd2;
			end else if ((b & MASK_TOP5) == LEAD4_BITS && b <= LEAD4_MAX) begin
				seq_lead = b;
				seq_need = 2'd3;
			end else begin
				count_sequence(1'b0);
			end
		end else if (seq_need == 2'd1) begin
			judge_sequence(b);
			seq_need = 2'd0;
			seq_held = 2'd0;
			seq_lead = 8'h00;
		end else begin
			seq_follow[seq_held[0]] = b;
			seq_held = seq_held + 2'd1;
			seq_need = seq_need - 2'd1;
		end
	endfunction

	// A lead still waiting at the end of a buffer counts as one bad sequence,
	// and the bytes held after it are parsed again as fresh input.
	function automatic void flush_tail();
		logic [7:0] replay0;
		logic [7:0] replay1;
		int         n;
		while (seq_need != 2'd0) begin
			n = (seq_held > 2'd2) ? 2 : int'(seq_held);
			replay0 = seq_follow[0];
			replay1 = seq_follow[1];
			count_sequence(1'b0);
			seq_need = 2'd0;
			seq_held = 2'd0;
			seq_lead = 8'h00;
			if (n >= 1) parse_byte(replay0);
			if (n >= 2) parse_byte(replay1);
		end
	endfunction

	function automatic ratio_t validity_ratio(input count_t v, input count_t t);
		logic [COUNT_WIDTH+RATIO_FRACTION_BITS:0] scaled;
		if (t == '0)
			return ratio_t'(1) << RATIO_FRACTION_BITS;
		scaled = {{(RATIO_FRACTION_BITS+1){1'b0}}, v} << RATIO_FRACTION_BITS;
		scaled = scaled / t;
		return scaled[RATIO_WIDTH-1:0];
	endfunction

	function automatic void predict_request(input logic [7:0] b, input logic has,
			input logic fin);
		buffer_counts_t summary;
		if (has)
			parse_byte(b);
		if (fin) begin
			flush_tail();
			summary.valid = valid_tally;
			summary.total = total_tally;
			summary.ratio = validity_ratio(valid_tally, total_tally);
			expected_counts_q.push_back(summary);
			clear_parser();
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
		while (!no_idle_send && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= has;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_request(b, has, fin);
		if (has || fin)
			items_sent++;
	endtask

	// Sends the low len bytes of seq, most significant first, with an
	// occasional idle request slipped in before a byte.
	task automatic send_seq(input logic [31:0] seq, input int len, input bit ends_buffer);
		for (int k = len - 1; k >= 0; k--) begin
			if ($urandom_range(99) < 3)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(seq[8*k +: 8], 1'b1, ends_buffer && k == 0);
		end
	endtask

	task automatic send_buffer(input int n_seq);
		logic [31:0] seq;
		logic [7:0]  lead;
		logic [7:0]  second;
		int          len;
		int          kind;
		bit          end_on_byte;
		end_on_byte = $urandom_range(99) < 70;
		for (int i = 0; i < n_seq; i++) begin
			kind = $urandom_range(99);
			seq  = $urandom;
			len  = 1;
			if (kind < 30) begin
				seq[7:0] = 8'($urandom_range(0, 127));
			end else if (kind < 70) begin
				len = $urandom_range(2, 4);
				seq = (seq & 32'h3F3F3F3F) | 32'h80808080;
				case (len)
					2: lead = 8'($urandom_range(8'hC2, 8'hDF));
					3: begin
						if ($urandom_range(99) < 40)
							lead = $urandom_range(1) ? LEAD_E0 : LEAD_ED;
						else
							lead = 8'($urandom_range(8'hE0, 8'hEF));
					end
					default: begin
						if ($urandom_range(99) < 50)
							lead = $urandom_range(1) ? LEAD_F0 : LEAD_F4;
						else
							lead = 8'($urandom_range(8'hF0, 8'hF4));
					end
				endcase
				case (lead)
					LEAD_E0: second = 8'($urandom_range(8'hA0, 8'hBF));
					LEAD_ED: second = 8'($urandom_range(8'h80, 8'h9F));
					LEAD_F0: second = 8'($urandom_range(8'h90, 8'hBF));
					LEAD_F4: second = 8'($urandom_range(8'h80, 8'h8F));
					default: second = 8'($urandom_range(8'h80, 8'hBF));
				endcase
				if ($urandom_range(99) < 20)
					second = 8'($urandom_range(8'h80, 8'hBF));
				seq[8*len-1 -: 8] = lead;
				seq[8*len-9 -: 8] = second;
			end else if (kind < 85) begin
				len = $urandom_range(1, 4);
				seq[8*len-1 -: 8] = 8'($urandom_range(8'hC2, 8'hF4));
			end
			send_seq(seq, len, end_on_byte && i == n_seq - 1);
		end
		if (!end_on_byte || n_seq == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_counts_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_byte_classes();
		send_seq(32'h007F80C1, 4, 1'b0);
		send_seq(32'h0000F5FF, 2, 1'b1);
	endtask

	task automatic test_lead_rules();
		send_seq(32'h0000C2C0, 2, 1'b0);
		send_seq(32'h00E09F80, 3, 1'b0);
		send_seq(32'h00ED9FBF, 3, 1'b0);
		send_seq(32'hF0908080, 4, 1'b0);
		send_seq(32'hF4908080, 4, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
	endtask

	task automatic test_truncated_tails();
		send_seq(32'h0000E180, 2, 1'b1);
		send_seq(32'h00F1C3A9, 3, 1'b1);
	endtask

	task automatic test_empty_and_idle();
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_full_rate_stream();
		no_idle_send = 1'b1;
		no_idle_recv = 1'b1;
		repeat (8)
			send_buffer($urandom_range(4, 16));
		no_idle_send = 1'b0;
		no_idle_recv = 1'b0;
	endtask

	// The receiver is held off while several short buffers keep coming, so
	// the result register fills and the input side has to stall.
	task automatic test_receiver_holdoff();
		-> hold_off_go;
		repeat (6)
			send_buffer($urandom_range(1, 4));
	endtask

	task automatic test_sender_drain_pause();
		repeat (3)
			send_buffer($urandom_range(1, 10));
		wait_all_results();
		repeat (3)
			send_buffer($urandom_range(1, 10));
	endtask

	task automatic test_random_buffers();
		while (items_sent < ITEM_TARGET)
			send_buffer(($urandom_range(99) < 5) ? 0 : $urandom_range(1, 20));
	endtask

	always begin
		@(hold_off_go);
		holding <= 1'b1;
		repeat (HOLD_OFF_CYCLES)
			@(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin : result_check
		buffer_counts_t want;
		buffer_counts_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.valid = m_tdata[COUNT_WIDTH-1:0];
				got.total = m_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
				got.ratio = m_tdata[2*COUNT_WIDTH +: RATIO_WIDTH];
				if (expected_counts_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: none expected, got valid=%0d total=%0d ratio=%h",
							results_seen, got.valid, got.total, got.ratio);
				end else begin
					want = expected_counts_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected %0d %0d %h, got %0d %0d %h",
								results_seen, want.valid, want.total, want.ratio,
								got.valid, got.total, got.ratio);
					end
				end
			end
			m_tready <= !holding && (no_idle_recv || $urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("utf8_validity_ratio_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		clear_parser();
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_classes();
		test_lead_rules();
		test_truncated_tails();
		test_empty_and_idle();
		test_full_rate_stream();
		test_receiver_holdoff();
		test_sender_drain_pause();
		test_random_buffers();
		wait_all_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && expected_counts_q.size() == 0)
			$display("utf8_validity_ratio_unit: match");
		else
			$display("utf8_validity_ratio_unit: mismatch");
		$finish;
	end

endmodule
